@@ rtl/tsrn_pkg.sv @@
// ----------------------------------------------------------------------------
// tsrn_pkg: shared constants and table functions
// Single-precision constants and the two seed tables used by the
// reciprocal square root / square root pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tsrn_pkg;

  // Single-precision bit patterns used by the datapath.
  localparam logic [31:0] FP_QNAN          = 32'h7FC0_0000;
  localparam logic [31:0] FP_HALF          = 32'h3F00_0000;
  localparam logic [31:0] FP_THREE_HALVES  = 32'h3FC0_0000;
  localparam logic [31:0] FP_ONE           = 32'h3F80_0000;

  // Exponent table entry: 2^((127-c)/2) with c the exponent clamped to 1..254.
  function automatic logic [31:0] exp_rom_f(input logic [7:0] e);
    logic [8:0] c;
    logic [31:0] bits;
    c = {1'b0, e};
    if (c < 9'd1) c = 9'd1;
    if (c > 9'd254) c = 9'd254;
    if (c[0]) begin
      bits = {1'b0, 8'((9'd381 - c) >> 1), 23'd0};
    end else begin
      bits = {1'b0, 8'((9'd380 - c) >> 1), 23'h3504F3};
    end
    return bits;
  endfunction

  // Mantissa table entry j of n: 1/sqrt(1 + j/n) rounded to single precision.
  // The largest m with (2m-1)^2 * (n+j) <= 2^50 * n is found by bisection.
  function automatic logic [31:0] mant_rom_f(input int unsigned j, input int unsigned n);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] t;
    logic [63:0] d;
    logic [63:0] target;
    logic [31:0] bits;
    lo     = 64'd1 << 23;
    hi     = (64'd1 << 24) - 64'd1;
    d      = 64'(n) + 64'(j);
    target = (64'd1 << 50) * 64'(n);
    for (int k = 0; k < 24; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        t   = (mid << 1) - 64'd1;
        if (t * t * d <= target) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    if (j == 0) begin
      bits = FP_ONE;
    end else begin
      bits = {1'b0, 8'd126, 23'(lo - (64'd1 << 23))};
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tsrn_if.sv @@
// ----------------------------------------------------------------------------
// tsrn_if: stream channels of the square root unit
// Sample channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsrn_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_bits;
  logic        mode;

  modport source (output valid, output sample_bits, output mode, input ready);
  modport sink   (input valid, input sample_bits, input mode, output ready);
endinterface

interface tsrn_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;

  modport source (output valid, output result_bits, input ready);
  modport sink   (input valid, input result_bits, output ready);
endinterface

`default_nettype wire

@@ rtl/tsrn_delay.sv @@
// ----------------------------------------------------------------------------
// tsrn_delay: enabled shift register
// Carries side data alongside an arithmetic unit of the same latency.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrn_delay #(
  parameter int W = 32,
  parameter int D = 3
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic      [W-1:0] q
);

  logic [W-1:0] taps [D];

  // Shift one place whenever the pipeline advances.
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < D; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[D-1];

endmodule

`default_nettype wire

@@ rtl/tsrn_fmul.sv @@
// ----------------------------------------------------------------------------
// tsrn_fmul: pipelined single-precision multiplier
// Three stages: mantissa product, leading-zero count, shift and round to
// nearest even. Subnormals are handled in full; NaN results are canonical.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrn_fmul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);
  import tsrn_pkg::*;

  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [7:0]  ea, eb;

  logic        s1_sign, s1_nan, s1_inf;
  logic [47:0] s1_prod;
  logic [9:0]  s1_esum;

  logic [5:0]         lz;
  logic signed [10:0] be_c, sh_c;

  logic               s2_sign, s2_nan, s2_inf, s2_zero;
  logic [47:0]        s2_prod;
  logic signed [10:0] s2_be, s2_sh;

  logic [10:0]  k;
  logic [5:0]   kc;
  logic [111:0] wide;
  logic [47:0]  q;
  logic         lost, rnd;
  logic [7:0]   expf;
  logic [30:0]  packed_c;

  // Stage 1: unpack, classify, multiply mantissas.
  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = a[30:0] == 31'd0;
    b_zero = b[30:0] == 31'd0;
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign <= a[31] ^ b[31];
      s1_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      s1_inf  <= a_inf | b_inf;
      s1_prod <= ma * mb;
      s1_esum <= 10'(ea) + 10'(eb);
    end
  end

  // Stage 2: leading zeros and the normalizing shift.
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (s1_prod[i]) lz = 6'(47 - i);
    end
    be_c = $signed({1'b0, s1_esum}) - 11'sd126 - $signed({5'b0, lz});
    if (be_c > 11'sd0) begin
      sh_c = $signed({5'b0, lz});
    end else begin
      sh_c = $signed({5'b0, lz}) + be_c - 11'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign <= s1_sign;
      s2_nan  <= s1_nan;
      s2_inf  <= s1_inf;
      s2_zero <= s1_prod == 48'd0;
      s2_prod <= s1_prod;
      s2_be   <= be_c;
      s2_sh   <= sh_c;
    end
  end

  // Stage 3: shift into place, round to nearest even, pack.
  always_comb begin
    k    = 11'(-s2_sh);
    kc   = (k > 11'd63) ? 6'd63 : k[5:0];
    wide = {s2_prod, 64'd0} >> kc;
    if (!s2_sh[10]) begin
      q    = s2_prod << s2_sh[5:0];
      lost = 1'b0;
    end else begin
      q    = wide[111:64];
      lost = |wide[63:0];
    end
    rnd      = q[23] & (q[24] | (|q[22:0]) | lost);
    expf     = (s2_be > 11'sd0) ? s2_be[7:0] : 8'd0;
    packed_c = {expf, q[46:24]} + 31'(rnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (s2_nan) begin
        y <= FP_QNAN;
      end else if (s2_inf) begin
        y <= {s2_sign, 8'hFF, 23'd0};
      end else if (s2_zero) begin
        y <= {s2_sign, 31'd0};
      end else if (s2_be > 11'sd254) begin
        y <= {s2_sign, 8'hFF, 23'd0};
      end else begin
        y <= {s2_sign, packed_c};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tsrn_fsub.sv @@
// ----------------------------------------------------------------------------
// tsrn_fsub: pipelined single-precision subtractor
// Computes a - b in three stages: align, add with leading-zero count,
// normalize and round to nearest even. NaN results are canonical.
// ----------------------------------------------------------------------------
`default_nettype none

module tsrn_fsub (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] y
);
  import tsrn_pkg::*;

  logic [31:0] bn, big, sml;
  logic        a_nan, b_nan, a_inf, b_inf;
  logic [7:0]  e_big, e_sml, d;
  logic [4:0]  dc;
  logic [58:0] ext;

  logic        s1_sign, s1_sub, s1_nan, s1_inf, s1_inf_sign;
  logic [7:0]  s1_exp;
  logic [26:0] s1_mbig, s1_msml;

  logic [27:0] sum_c;
  logic [4:0]  lz;

  logic        s2_sign, s2_sub, s2_nan, s2_inf, s2_inf_sign;
  logic [7:0]  s2_exp;
  logic [27:0] s2_sum;
  logic [4:0]  s2_lz;

  logic signed [9:0] be;
  logic [7:0]  sh;
  logic [27:0] q;
  logic        rnd;
  logic [7:0]  expf;
  logic [30:0] packed_c;

  // Stage 1: negate b, order by magnitude, align the smaller operand.
  always_comb begin
    bn    = {~b[31], b[30:0]};
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    if (a[30:0] >= bn[30:0]) begin
      big = a;
      sml = bn;
    end else begin
      big = bn;
      sml = a;
    end
    e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d     = e_big - e_sml;
    dc    = (d > 8'd31) ? 5'd31 : d[4:0];
    ext   = {sml[30:23] != 8'd0, sml[22:0], 3'b000, 32'd0} >> dc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sign     <= big[31];
      s1_sub      <= big[31] ^ sml[31];
      s1_nan      <= a_nan | b_nan | (a_inf & b_inf & (a[31] == b[31]));
      s1_inf      <= a_inf | b_inf;
      s1_inf_sign <= a_inf ? a[31] : bn[31];
      s1_exp      <= e_big;
      s1_mbig     <= {big[30:23] != 8'd0, big[22:0], 3'b000};
      s1_msml     <= ext[58:32] | {26'd0, |ext[31:0]};
    end
  end

  // Stage 2: add or subtract magnitudes and count leading zeros.
  always_comb begin
    if (s1_sub) begin
      sum_c = {1'b0, s1_mbig} - {1'b0, s1_msml};
    end else begin
      sum_c = {1'b0, s1_mbig} + {1'b0, s1_msml};
    end
    lz = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (sum_c[i]) lz = 5'(27 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sign     <= s1_sign;
      s2_sub      <= s1_sub;
      s2_nan      <= s1_nan;
      s2_inf      <= s1_inf;
      s2_inf_sign <= s1_inf_sign;
      s2_exp      <= s1_exp;
      s2_sum      <= sum_c;
      s2_lz       <= lz;
    end
  end

  // Stage 3: normalize (stopping at the subnormal range), round, pack.
  always_comb begin
    be       = $signed({2'b0, s2_exp}) + 10'sd1 - $signed({5'b0, s2_lz});
    sh       = (be > 10'sd0) ? {3'b0, s2_lz} : s2_exp;
    q        = s2_sum << sh;
    rnd      = q[3] & (q[4] | (|q[2:0]));
    expf     = (be > 10'sd0) ? be[7:0] : 8'd0;
    packed_c = {expf, q[26:4]} + 31'(rnd);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (s2_nan) begin
        y <= FP_QNAN;
      end else if (s2_inf) begin
        y <= {s2_inf_sign, 8'hFF, 23'd0};
      end else if (s2_sum == 28'd0) begin
        // An exact zero difference is +0; a sum of like-signed zeros keeps the sign.
        y <= {s2_sub ? 1'b0 : s2_sign, 31'd0};
      end else if (be > 10'sd254) begin
        y <= {s2_sign, 8'hFF, 23'd0};
      end else begin
        y <= {s2_sign, packed_c};
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/table_sqrt_rsqrt_newton_top.sv @@
// Throughput: one sample per cycle; the pipeline of six multiplier levels and
// one subtractor (three stages each) advances whenever the output is free.
// Reset: rst clears all valid bits and the output valid; no ROM clearing pass.
// ----------------------------------------------------------------------------
// table_sqrt_rsqrt_newton_top: table-seeded reciprocal square root / sqrt
// Seeds 1/sqrt(x) from an exponent table and a mantissa table, applies one
// Newton step, and in square-root mode multiplies the refined value by x.
// ----------------------------------------------------------------------------
`default_nettype none

module table_sqrt_rsqrt_newton_top #(
  parameter int MANTISSA_TABLE_DEPTH = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  tsrn_in_if.sink       samples,
  tsrn_out_if.source    results
);
  import tsrn_pkg::*;

  localparam int IW   = $clog2(MANTISSA_TABLE_DEPTH);
  localparam int PW   = 23 + $clog2(MANTISSA_TABLE_DEPTH + 1);
  localparam int NVLD = 22;

  logic en;
  logic [NVLD-1:0] vld;
  logic out_valid;

  logic [PW-1:0] idx_prod;
  logic [IW-1:0] midx;
  logic [31:0]   mrom [MANTISSA_TABLE_DEPTH];
  logic          neg_c;

  logic [31:0] x0, eg0, mg0;
  logic        mode0, neg0;

  logic [31:0] g1, h2, q2, p4, p5, p6, r7, y8;
  logic [33:0] side1;
  logic [65:0] side2;
  logic [97:0] side3;
  logic [65:0] side4, side5;
  logic [33:0] side6;
  logic [33:0] side7;
  logic [31:0] res_c;

  // The whole pipeline moves unless a finished result is held at the output.
  assign en            = !out_valid || results.ready;
  assign samples.ready = en;

  // Mantissa seed table.
  for (genvar j = 0; j < MANTISSA_TABLE_DEPTH; j++) begin : g_mrom
    assign mrom[j] = mant_rom_f(j, MANTISSA_TABLE_DEPTH);
  end

  // Table index is the mantissa scaled by the table depth.
  always_comb begin
    idx_prod = PW'(samples.sample_bits[22:0]) * PW'(MANTISSA_TABLE_DEPTH);
    midx     = idx_prod[23 +: IW];
    neg_c    = samples.sample_bits[31] && (samples.sample_bits[30:0] != 31'd0) &&
               !((samples.sample_bits[30:23] == 8'hFF) && (samples.sample_bits[22:0] != 23'd0));
  end

  // Seed stage: both table reads registered.
  always_ff @(posedge clk) begin
    if (en) begin
      x0    <= samples.sample_bits;
      mode0 <= samples.mode;
      neg0  <= neg_c;
      eg0   <= exp_rom_f(samples.sample_bits[30:23]);
      mg0   <= mrom[midx];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[NVLD-2:0], samples.valid};
      out_valid <= vld[NVLD-1];
    end
  end

  // Initial guess g.
  tsrn_fmul u_mul_g (.clk(clk), .en(en), .a(eg0), .b(mg0), .y(g1));
  tsrn_delay #(.W(34), .D(3)) u_d1 (.clk(clk), .en(en), .d({x0, mode0, neg0}), .q(side1));

  // 0.5g and 1.5g side by side.
  tsrn_fmul u_mul_h (.clk(clk), .en(en), .a(FP_HALF), .b(g1), .y(h2));
  tsrn_fmul u_mul_q (.clk(clk), .en(en), .a(FP_THREE_HALVES), .b(g1), .y(q2));
  tsrn_delay #(.W(66), .D(3)) u_d2 (.clk(clk), .en(en), .d({side1, g1}), .q(side2));

  // (0.5g * g)
  tsrn_fmul u_mul_p1 (.clk(clk), .en(en), .a(h2), .b(side2[31:0]), .y(p4));
  tsrn_delay #(.W(98), .D(3)) u_d3 (.clk(clk), .en(en), .d({side2, q2}), .q(side3));

  // ((0.5g * g) * g)
  tsrn_fmul u_mul_p2 (.clk(clk), .en(en), .a(p4), .b(side3[63:32]), .y(p5));
  tsrn_delay #(.W(66), .D(3)) u_d4 (.clk(clk), .en(en),
                                    .d({side3[97:64], side3[31:0]}), .q(side4));

  // (((0.5g * g) * g) * x)
  tsrn_fmul u_mul_p3 (.clk(clk), .en(en), .a(p5), .b(side4[65:34]), .y(p6));
  tsrn_delay #(.W(66), .D(3)) u_d5 (.clk(clk), .en(en), .d(side4), .q(side5));

  // Newton step result r = 1.5g - p.
  tsrn_fsub u_sub (.clk(clk), .en(en), .a(side5[31:0]), .b(p6), .y(r7));
  tsrn_delay #(.W(34), .D(3)) u_d6 (.clk(clk), .en(en), .d(side5[65:32]), .q(side6));

  // Square root: x * r.
  tsrn_fmul u_mul_y (.clk(clk), .en(en), .a(side6[33:2]), .b(r7), .y(y8));
  tsrn_delay #(.W(34), .D(3)) u_d7 (.clk(clk), .en(en), .d({side6[1:0], r7}), .q(side7));

  // Result select: negative samples give +0, square-root mode gives x * r, else r.
  always_comb begin
    if (side7[32]) begin
      res_c = 32'd0;
    end else if (side7[33]) begin
      res_c = y8;
    end else begin
      res_c = side7[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      results.result_bits <= res_c;
    end
  end

  assign results.valid = out_valid;

endmodule

`default_nettype wire

@@ test/table_sqrt_rsqrt_newton_top_tb.sv @@
// ----------------------------------------------------------------------------
// table_sqrt_rsqrt_newton_top_tb: self-checking bench for the root unit
// Streams single-precision samples in both modes through the unit, predicts
// every result with a bit-exact soft-float model of the table seed and the
// Newton step, and compares each result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module table_sqrt_rsqrt_newton_top_tb;
  import tsrn_pkg::*;

  localparam int MANT_DEPTH = 1024;
  localparam int STALL_LIMIT = 3000;

  logic clk;
  logic rst;

  tsrn_in_if  in_ch ();
  tsrn_out_if out_ch ();

  table_sqrt_rsqrt_newton_top #(.MANTISSA_TABLE_DEPTH(MANT_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (in_ch),
    .results (out_ch)
  );

  logic [32:0] sample_queue[$];   // {sample_bits, mode}
  logic [31:0] root_queue[$];     // predicted result_bits
  logic [31:0] mant_seed[MANT_DEPTH];
  int          mismatch_count;
  int          results_seen;
  int          drive_gap;
  int          recv_gap;
  int          recv_hold;
  bit          hold_done;
  int          idle_cycles;
  int          calm_left;

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Soft-float helpers.
  function automatic bit is_nan(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] != 0);
  endfunction

  function automatic bit is_inf(input logic [31:0] a);
    return (a[30:23] == 8'hff) && (a[22:0] == 0);
  endfunction

  function automatic void unpack_fp(input logic [31:0] a, output logic [63:0] m,
                                    output int ex);
    if (a[30:23] == 0) begin
      m  = {41'd0, a[22:0]};
      ex = -149;
    end else begin
      m  = {40'd0, 1'b1, a[22:0]};
      ex = int'(a[30:23]) - 150;
    end
  endfunction

  // Round m * 2^ex to single precision, nearest even, with subnormals.
  function automatic logic [31:0] round_pack(input logic sgn, input logic [63:0] m,
                                             input int ex);
    int msb;
    int shift;
    int sh;
    int lsb_exp;
    int be;
    logic [191:0] w;
    logic [63:0] q;
    if (m == 0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 64; i++) if (m[i]) msb = i;
    shift = msb - 23;
    if (-149 - ex > shift) shift = -149 - ex;
    if (shift <= 0) begin
      q = m << (-shift);
    end else begin
      sh = (shift > 128) ? 128 : shift;
      w = {m, 128'd0} >> sh;
      q = w[191:128];
      if (w[127] && ((|w[126:0]) || q[0])) q = q + 64'd1;
    end
    lsb_exp = ex + shift;
    if (q[24]) begin
      q = q >> 1;
      lsb_exp++;
    end
    if (!q[23]) return {sgn, 8'd0, q[22:0]};
    be = lsb_exp + 150;
    if (be >= 255) return {sgn, 8'hff, 23'd0};
    return {sgn, 8'(be), q[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    logic [63:0] ma;
    logic [63:0] mb;
    int ea;
    int eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return FP_QNAN;
    if (is_inf(a)) return (b[30:0] == 0) ? FP_QNAN : {sgn, 8'hff, 23'd0};
    if (is_inf(b)) return (a[30:0] == 0) ? FP_QNAN : {sgn, 8'hff, 23'd0};
    if (a[30:0] == 0 || b[30:0] == 0) return {sgn, 31'd0};
    unpack_fp(a, ma, ea);
    unpack_fp(b, mb, eb);
    return round_pack(sgn, ma * mb, ea + eb);
  endfunction

  // a - b with single rounding.
  function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] bn);
    logic [31:0] b;
    logic [31:0] tmp;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] big;
    logic [63:0] little;
    logic [63:0] m;
    logic sgn;
    int ea;
    int eb;
    int d;
    b = {~bn[31], bn[30:0]};
    if (is_nan(a) || is_nan(b)) return FP_QNAN;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? FP_QNAN : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    unpack_fp(a, ma, ea);
    unpack_fp(b, mb, eb);
    if (ea < eb) begin
      tmp = a; a = b; b = tmp;
      unpack_fp(a, ma, ea);
      unpack_fp(b, mb, eb);
    end
    d = ea - eb;
    big = ma << 38;
    // A far smaller operand only matters as a sticky bit.
    little = (d <= 38) ? (mb << (38 - d)) : 64'd1;
    if (a[31] == b[31]) begin
      m = big + little;
      sgn = a[31];
    end else if (big >= little) begin
      m = big - little;
      sgn = a[31];
    end else begin
      m = little - big;
      sgn = b[31];
    end
    if (m == 0) return 32'd0;
    return round_pack(sgn, m, ea - 38);
  endfunction

  // Exponent seed: 2^((127-c)/2) with c clamped to 1..254.
  function automatic logic [31:0] exp_seed(input logic [7:0] e);
    int c;
    c = int'(e);
    if (c < 1) c = 1;
    if (c > 254) c = 254;
    if (c % 2 == 1) return {1'b0, 8'((381 - c) / 2), 23'd0};
    return {1'b0, 8'((380 - c) / 2), 23'h3504F3};
  endfunction

  // Expected result_bits for one sample.
  function automatic logic [31:0] predict_root(input logic [31:0] x, input logic mode);
    logic [31:0] g;
    logic [31:0] p;
    logic [31:0] q;
    logic [31:0] r;
    logic [63:0] idx;
    if (x[31] && !is_nan(x) && x[30:0] != 0) return 32'd0;
    idx = (64'(x[22:0]) * 64'(MANT_DEPTH)) >> 23;
    g = fp_mul(exp_seed(x[30:23]), mant_seed[idx]);
    p = fp_mul(FP_HALF, g);
    p = fp_mul(p, g);
    p = fp_mul(p, g);
    p = fp_mul(p, x);
    q = fp_mul(FP_THREE_HALVES, g);
    r = fp_sub(q, p);
    if (mode) r = fp_mul(x, r);
    if (is_nan(r)) r = FP_QNAN;
    return r;
  endfunction

  // Mostly no gap, sometimes short, rarely long, with calm stretches.
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 199);
    if (r < 2) calm_left = $urandom_range(50, 150);
    if (r < 110) return 0;
    if (r < 180) return $urandom_range(1, 3);
    if (r < 196) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_sample();
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: return $urandom();
      2: return {1'b1, 31'($urandom())};
      3: return {1'b0, 8'd0, 23'($urandom())};
      4: return {1'($urandom_range(0, 1)), 8'hff, 23'($urandom_range(0, 3) == 0 ? 0 :
                 $urandom())};
      5: return {1'b0, 8'($urandom_range(250, 255)), 23'($urandom())};
      6: return {1'b0, 8'($urandom_range(0, 5)), 23'($urandom())};
      default: return {1'b0, 8'($urandom_range(100, 154)), 23'($urandom())};
    endcase
  endfunction

  // Driver: presents queued samples, predicts on each accepted transaction.
  always @(posedge clk) begin
    logic [32:0] item;
    logic        offer;
    if (rst) begin
      in_ch.valid <= 1'b0;
      drive_gap = 0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        root_queue.push_back(predict_root(in_ch.sample_bits, in_ch.mode));
        offer = 1'b0;
        drive_gap = pick_gap();
      end
      if (!offer) begin
        if (drive_gap > 0) begin
          drive_gap--;
        end else if (sample_queue.size() > 0) begin
          item = sample_queue.pop_front();
          in_ch.sample_bits <= item[32:1];
          in_ch.mode <= item[0];
          offer = 1'b1;
        end
      end
      in_ch.valid <= offer;
    end
  end

  // Monitor: checks each result transaction and shapes ready.
  always @(posedge clk) begin
    logic [31:0] want;
    logic        rdy;
    if (rst) begin
      out_ch.ready <= 1'b0;
      recv_gap = 0;
      recv_hold = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (root_queue.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result transaction: result_bits=%h", out_ch.result_bits);
        end else begin
          want = root_queue.pop_front();
          if (out_ch.result_bits !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result_bits mismatch: expected %h actual %h", want,
                       out_ch.result_bits);
          end
        end
        recv_gap = pick_gap();
      end
      // One long hold-off so the pipeline fills and back-pressures the input.
      if (!hold_done && results_seen >= 500) begin
        hold_done = 1'b1;
        recv_hold = 300;
      end
      rdy = 1'b1;
      if (recv_hold > 0) begin
        recv_hold--;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end
      out_ch.ready <= rdy;
    end
  end

  // Watchdog: counts cycles with work outstanding and no transaction.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else if (sample_queue.size() > 0 || in_ch.valid || root_queue.size() > 0) begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0] directed[$];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] t;
    in_ch.valid = 1'b0;
    in_ch.sample_bits = 32'd0;
    in_ch.mode = 1'b0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    mismatch_count = 0;
    results_seen = 0;
    hold_done = 1'b0;
    idle_cycles = 0;
    calm_left = 0;

    // Mantissa seeds: largest m with (2m-1)^2 * (N+j) <= 2^50 * N.
    for (int j = 0; j < MANT_DEPTH; j++) begin
      lo = 64'd1 << 23;
      hi = (64'd1 << 24) - 1;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        t = 2 * mid - 1;
        if (t * t * 64'(MANT_DEPTH + j) <= (64'd1 << 50) * 64'(MANT_DEPTH)) lo = mid;
        else hi = mid - 1;
      end
      mant_seed[j] = (j == 0) ? FP_ONE : {1'b0, 8'd126, 23'(lo - (64'd1 << 23))};
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: zeros, infinities, NaNs, subnormals, range ends, negatives.
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'hFFC0_0001, 32'h7F80_0001, 32'h0000_0001,
                 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000,
                 32'h4080_0000, 32'hBF80_0000, 32'h3FFF_FFFF, 32'h0040_0000,
                 32'hFFFF_FFFF, 32'h8000_0001, 32'h4000_0000, 32'h3F80_2000};
    foreach (directed[i]) begin
      sample_queue.push_back({directed[i], 1'b0});
      if (i % 3 == 0 || i < 6) sample_queue.push_back({directed[i], 1'b1});
    end

    // Random phases; the sender drains the unit between them.
    // The drain checks run at the falling edge, after the clocked updates settle.
    for (int ph = 0; ph < 5; ph++) begin
      while (sample_queue.size() > 0 || in_ch.valid || root_queue.size() > 0)
        @(negedge clk);
      for (int n = 0; n < 380; n++)
        sample_queue.push_back({random_sample(), 1'($urandom_range(0, 1))});
    end

    @(negedge clk);
    while (sample_queue.size() > 0 || in_ch.valid || root_queue.size() > 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && root_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
